// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/emgrep_pkg.sv
// ----------------------------------------------------------------------------
// emgrep_pkg
// Shared types, constants and helpers of the EMG rep detector.
// ----------------------------------------------------------------------------
package emgrep_pkg;

	localparam int RAW_W     = 12;
	localparam int TICK_W    = 16;
	localparam int PERIOD_W  = 8;
	localparam int WIDTH_W   = 24;
	localparam int REPS_W    = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 24;

	localparam int READS_PER_SAMPLE_DEF = 4;
	localparam int ADC_BITS_DEF         = 12;

	localparam logic [RAW_W-1:0]    TH_HIGH_RST  = 12'd1600;
	localparam logic [RAW_W-1:0]    TH_LOW_RST   = 12'd800;
	localparam logic [PERIOD_W-1:0] PERIOD_RST   = 8'd50;
	localparam logic [WIDTH_W-1:0]  MIN_PULSE_RST = 24'd250;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_HIGH = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LOW  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE      = 4'd3;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_DEAD  = 2'd1,
		EV_SHORT = 2'd2,
		EV_REP   = 2'd3
	} event_t;

	typedef struct packed {
		logic [RAW_W-1:0]    th_high;
		logic [RAW_W-1:0]    th_low;
		logic [PERIOD_W-1:0] tick_period;
		logic [WIDTH_W-1:0]  min_pulse;
	} cfg_t;

	function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
		return (v == '1) ? v : v + TICK_W'(1);
	endfunction

endpackage

// File: rtl/emg_rep_detector.sv
// ----------------------------------------------------------------------------
// emg_rep_detector
// Counts exercise reps from a stream of raw EMG conversions.
//
// Input channel (in_valid/in_ready, raw_reading) takes one raw conversion per
// beat. Every READS_PER_SAMPLE beats form one averaged sample, and each
// sample yields exactly one result beat on the output channel
// (out_valid/out_ready, event_code, width_ms, rep_total, in_rep_flag,
// averaged_sample); other input beats yield nothing.
// A group's result, once its last conversion is accepted, passes through the
// sum stage, divide stage and detector result register before out_valid.
// Throughput: the three-stage pipeline takes one input beat per cycle unless
// the receiver stalls; then up to three samples are held in the stages before
// in_ready drops; conversions that do not close a group are always taken.
// Configuration beats (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken
// every cycle; unknown indexes are dropped. Write only while idle.
// Reset clears the accumulator, counters, rep total and history, and loads
// the default thresholds, tick period and minimum pulse width.
// ----------------------------------------------------------------------------
module emg_rep_detector #(
	parameter int READS_PER_SAMPLE = emgrep_pkg::READS_PER_SAMPLE_DEF,
	parameter int ADC_BITS         = emgrep_pkg::ADC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [emgrep_pkg::RAW_W-1:0]     raw_reading,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       event_code,
	output logic [emgrep_pkg::WIDTH_W-1:0]   width_ms,
	output logic [emgrep_pkg::REPS_W-1:0]    rep_total,
	output logic                             in_rep_flag,
	output logic [emgrep_pkg::RAW_W-1:0]     averaged_sample,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [emgrep_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [emgrep_pkg::CFG_DAT_W-1:0] cfg_data
);

	emgrep_pkg::cfg_t                cfg_q;
	logic                            smp_valid;
	logic                            smp_ready;
	logic [emgrep_pkg::RAW_W-1:0]    smp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.th_high     <= emgrep_pkg::TH_HIGH_RST;
			cfg_q.th_low      <= emgrep_pkg::TH_LOW_RST;
			cfg_q.tick_period <= emgrep_pkg::PERIOD_RST;
			cfg_q.min_pulse   <= emgrep_pkg::MIN_PULSE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				emgrep_pkg::REG_THRESHOLD_HIGH: begin
					cfg_q.th_high <= cfg_data[emgrep_pkg::RAW_W-1:0];
				end
				emgrep_pkg::REG_THRESHOLD_LOW: begin
					cfg_q.th_low <= cfg_data[emgrep_pkg::RAW_W-1:0];
				end
				emgrep_pkg::REG_TICK_PERIOD: begin
					cfg_q.tick_period <= cfg_data[emgrep_pkg::PERIOD_W-1:0];
				end
				emgrep_pkg::REG_MIN_PULSE: begin
					cfg_q.min_pulse <= cfg_data[emgrep_pkg::WIDTH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	emgrep_avg #(
		.READS_PER_SAMPLE(READS_PER_SAMPLE),
		.ADC_BITS        (ADC_BITS)
	) u_avg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.raw_reading(raw_reading),
		.smp_valid  (smp_valid),
		.smp_ready  (smp_ready),
		.smp        (smp)
	);

	emgrep_det u_det (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.smp_valid      (smp_valid),
		.smp_ready      (smp_ready),
		.smp            (smp),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_code     (event_code),
		.width_ms       (width_ms),
		.rep_total      (rep_total),
		.in_rep_flag    (in_rep_flag),
		.averaged_sample(averaged_sample)
	);

endmodule

// File: rtl/emgrep_avg.sv
// ----------------------------------------------------------------------------
// emgrep_avg
// Sums each group of raw conversions and divides by the group size.
// ----------------------------------------------------------------------------
module emgrep_avg #(
	parameter int READS_PER_SAMPLE = emgrep_pkg::READS_PER_SAMPLE_DEF,
	parameter int ADC_BITS         = emgrep_pkg::ADC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [emgrep_pkg::RAW_W-1:0] raw_reading,
	output logic                        smp_valid,
	input  logic                        smp_ready,
	output logic [emgrep_pkg::RAW_W-1:0] smp
);

	localparam int RAW_W  = emgrep_pkg::RAW_W;
	localparam int DIV_L  = $clog2(READS_PER_SAMPLE);
	localparam int SUM_W  = RAW_W + DIV_L;
	localparam int M_W    = SUM_W + 1;
	localparam int SH     = SUM_W + DIV_L;
	localparam int CNT_W  = (READS_PER_SAMPLE > 1) ? $clog2(READS_PER_SAMPLE) : 1;
	localparam int KEEP   = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
	localparam longint DIV_M =
		((longint'(1) << SH) + longint'(READS_PER_SAMPLE) - 1) / longint'(READS_PER_SAMPLE);
	localparam logic [M_W-1:0]   DIV_M_V  = M_W'(DIV_M);
	localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((longint'(1) << KEEP) - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(READS_PER_SAMPLE - 1);

	logic [SUM_W-1:0]     acc_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]     sum_s1;
	logic                 v_s1;
	logic [RAW_W-1:0]     avg_s2;
	logic                 v_s2;
	logic                 last;
	logic                 accept;
	logic                 s1_ready;
	logic                 s2_ready;
	logic [SUM_W-1:0]     sum_next;
	logic [SUM_W+M_W-1:0] prod;

	assign last     = (cnt_q == CNT_LAST);
	assign s2_ready = !v_s2 || smp_ready;
	assign s1_ready = !v_s1 || s2_ready;
	assign in_ready = !last || s1_ready;
	assign accept   = in_valid && in_ready;
	assign sum_next = acc_q + SUM_W'(raw_reading & RAW_MASK);

	// reciprocal multiply, exact floor for every sum below 2**SUM_W
	assign prod = {{M_W{1'b0}}, sum_s1} * {{SUM_W{1'b0}}, DIV_M_V};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (accept) begin
				if (last) begin
					acc_q <= '0;
					cnt_q <= '0;
				end else begin
					acc_q <= sum_next;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			v_s1 <= (v_s1 && !s2_ready) || (accept && last);
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			sum_s1 <= sum_next;
		end
		if (s2_ready && v_s1) begin
			avg_s2 <= prod[SH +: RAW_W];
		end
	end

	assign smp_valid = v_s2;
	assign smp       = avg_s2;

endmodule

// File: rtl/emgrep_det.sv
// ----------------------------------------------------------------------------
// emgrep_det
// Two-threshold rep detector with pulse/dead counters and result register.
// ----------------------------------------------------------------------------
module emgrep_det (
	input  logic                           clk,
	input  logic                           arst_n,
	input  emgrep_pkg::cfg_t               cfg,
	input  logic                           smp_valid,
	output logic                           smp_ready,
	input  logic [emgrep_pkg::RAW_W-1:0]   smp,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     event_code,
	output logic [emgrep_pkg::WIDTH_W-1:0] width_ms,
	output logic [emgrep_pkg::REPS_W-1:0]  rep_total,
	output logic                           in_rep_flag,
	output logic [emgrep_pkg::RAW_W-1:0]   averaged_sample
);

	localparam int RAW_W    = emgrep_pkg::RAW_W;
	localparam int TICK_W   = emgrep_pkg::TICK_W;
	localparam int PERIOD_W = emgrep_pkg::PERIOD_W;
	localparam int WIDTH_W  = emgrep_pkg::WIDTH_W;
	localparam int REPS_W   = emgrep_pkg::REPS_W;

	logic [RAW_W-1:0]   prev_q;
	logic               prev_valid_q;
	logic               in_rep_q;
	logic [TICK_W-1:0]  pulse_q;
	logic [TICK_W-1:0]  dead_q;
	logic [REPS_W-1:0]  reps_q;
	logic               out_valid_q;
	emgrep_pkg::event_t out_code_q;
	logic [WIDTH_W-1:0] out_width_q;
	logic [RAW_W-1:0]   out_smp_q;

	logic [RAW_W-1:0]   prev_n;
	logic               in_rep_n;
	logic [TICK_W-1:0]  pulse_n;
	logic [TICK_W-1:0]  dead_n;
	logic [REPS_W-1:0]  reps_n;
	emgrep_pkg::event_t code_n;
	logic [WIDTH_W-1:0] width_n;
	logic [WIDTH_W-1:0] dead_ms;
	logic [WIDTH_W-1:0] pulse_ms;
	logic               fire;

	// 16x8 product never exceeds 24 bits, so no saturation is needed
	assign dead_ms  = {{PERIOD_W{1'b0}}, dead_q} * {{TICK_W{1'b0}}, cfg.tick_period};
	assign pulse_ms = {{PERIOD_W{1'b0}}, pulse_q} * {{TICK_W{1'b0}}, cfg.tick_period};

	assign smp_ready = !out_valid_q || out_ready;
	assign fire      = smp_valid && smp_ready;

	always_comb begin
		prev_n   = prev_q;
		in_rep_n = in_rep_q;
		pulse_n  = pulse_q;
		dead_n   = dead_q;
		reps_n   = reps_q;
		code_n   = emgrep_pkg::EV_NONE;
		width_n  = '0;
		priority if (smp >= cfg.th_high) begin
			if (prev_valid_q && (prev_q >= cfg.th_low)) begin
				in_rep_n = 1'b1;
				code_n   = emgrep_pkg::EV_DEAD;
				width_n  = dead_ms;
				dead_n   = '0;
				pulse_n  = emgrep_pkg::sat_inc(pulse_q);
			end
			prev_n = smp;
		end else if (smp >= cfg.th_low) begin
			if (in_rep_q) begin
				pulse_n = emgrep_pkg::sat_inc(pulse_q);
			end else begin
				dead_n = emgrep_pkg::sat_inc(dead_q);
			end
			prev_n = smp;
		end else begin
			if (prev_valid_q && (prev_q != '0)) begin
				in_rep_n = 1'b0;
				width_n  = pulse_ms;
				pulse_n  = '0;
				dead_n   = emgrep_pkg::sat_inc(dead_q);
				if (pulse_ms > cfg.min_pulse) begin
					code_n = emgrep_pkg::EV_REP;
					reps_n = emgrep_pkg::sat_inc(reps_q);
				end else begin
					code_n = emgrep_pkg::EV_SHORT;
				end
			end
			prev_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			in_rep_q     <= 1'b0;
			pulse_q      <= '0;
			dead_q       <= '0;
			reps_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (smp_ready) begin
				out_valid_q <= smp_valid;
			end
			if (fire) begin
				prev_q       <= prev_n;
				prev_valid_q <= 1'b1;
				in_rep_q     <= in_rep_n;
				pulse_q      <= pulse_n;
				dead_q       <= dead_n;
				reps_q       <= reps_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_code_q  <= code_n;
			out_width_q <= width_n;
			out_smp_q   <= smp;
		end
	end

	assign out_valid       = out_valid_q;
	assign event_code      = out_code_q;
	assign width_ms        = out_width_q;
	assign rep_total       = reps_q;
	assign in_rep_flag     = in_rep_q;
	assign averaged_sample = out_smp_q;

endmodule

// File: rtl/emgrep_checker.sv
// ----------------------------------------------------------------------------
// emgrep_checker
// Port-level checks of the rep detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module emgrep_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [1:0]                       event_code,
	input logic [emgrep_pkg::WIDTH_W-1:0]   width_ms,
	input logic [emgrep_pkg::REPS_W-1:0]    rep_total,
	input logic                             in_rep_flag,
	input logic [emgrep_pkg::RAW_W-1:0]     averaged_sample
);

	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(event_code) && $stable(width_ms) && $stable(averaged_sample)
		&& $stable(rep_total) && $stable(in_rep_flag),
		"stalled result beat changed")

	`ASSERT_IMP(a_none_zero, clk, arst_n, out_valid && (event_code == emgrep_pkg::EV_NONE),
		width_ms == '0, "no-event beat carries a width")

	`ASSERT_IMP(a_dead_in_rep, clk, arst_n, out_valid && (event_code == emgrep_pkg::EV_DEAD),
		in_rep_flag, "dead width reported outside a rep")

	`ASSERT_IMP(a_end_out_rep, clk, arst_n,
		out_valid && ((event_code == emgrep_pkg::EV_SHORT) || (event_code == emgrep_pkg::EV_REP)),
		!in_rep_flag, "pulse end left rep flag set")

endmodule

bind emg_rep_detector emgrep_checker u_chk (.*);

// File: sim/tb_emg_rep_detector.sv
// ----------------------------------------------------------------------------
// tb_emg_rep_detector
// Self-checking bench for the EMG rep detector.
//
// Raw conversions go in on the input channel. A behavioral model of the
// averaging and two-threshold detector runs on every accepted beat and queues
// the result each closed group should produce. Every output beat is compared
// field by field against the oldest queued result. Test tasks cover reset
// defaults and the detector corner cases, randomized register settings with
// rep-shaped sample runs, a long output stall that backs up the pipeline,
// and long dead and pulse runs at the widest tick period.
// ----------------------------------------------------------------------------
module tb_emg_rep_detector;
	timeunit 1ns;
	timeprecision 1ps;

	import emgrep_pkg::*;

	localparam int READS           = READS_PER_SAMPLE_DEF;
	localparam int RAW_MAX         = (1 << RAW_W) - 1;
	localparam int TICK_MAX        = (1 << TICK_W) - 1;
	localparam int REPS_MAX        = (1 << REPS_W) - 1;
	localparam longint WIDTH_MAX   = (longint'(1) << WIDTH_W) - 1;
	localparam int IDX_MAX         = (1 << CFG_IDX_W) - 1;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int LONG_HOLD       = 300;
	localparam int LONG_RUN        = 40;
	localparam int SETTLE_CYCLES   = 8;

	typedef enum {LVL_LOW, LVL_MID, LVL_HIGH} level_class_t;

	typedef struct {
		event_t              code;
		logic [WIDTH_W-1:0]  width;
		logic [REPS_W-1:0]   reps;
		logic                flag;
		logic [RAW_W-1:0]    avg;
	} rep_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [RAW_W-1:0]     raw_reading;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           event_code;
	logic [WIDTH_W-1:0]   width_ms;
	logic [REPS_W-1:0]    rep_total;
	logic                 in_rep_flag;
	logic [RAW_W-1:0]     averaged_sample;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	emg_rep_detector u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.raw_reading     (raw_reading),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_code      (event_code),
		.width_ms        (width_ms),
		.rep_total       (rep_total),
		.in_rep_flag     (in_rep_flag),
		.averaged_sample (averaged_sample),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// detector model state
	cfg_t        cur_cfg;
	int          acc_sum;
	int          acc_reads;
	int          last_level;
	bit          have_last;
	bit          pulse_active;
	int          run_ticks;
	int          idle_ticks;
	int          reps_done;
	rep_result_t pending_results[$];

	bit gaps_on = 1'b1;
	bit stall_on = 1'b1;
	int hold_left = 0;
	int err_count = 0;
	int readings_sent = 0;
	int results_checked = 0;
	int settings_loaded = 0;
	int code_seen[4] = '{default: 0};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [WIDTH_W-1:0] ticks_to_width(input int ticks);
		longint w;
		w = longint'(ticks) * longint'(cur_cfg.tick_period);
		return (w > WIDTH_MAX) ? WIDTH_W'(WIDTH_MAX) : WIDTH_W'(w);
	endfunction

	task automatic reset_model();
		cur_cfg.th_high     = TH_HIGH_RST;
		cur_cfg.th_low      = TH_LOW_RST;
		cur_cfg.tick_period = PERIOD_RST;
		cur_cfg.min_pulse   = MIN_PULSE_RST;
		acc_sum      = 0;
		acc_reads    = 0;
		last_level   = 0;
		have_last    = 1'b0;
		pulse_active = 1'b0;
		run_ticks    = 0;
		idle_ticks   = 0;
		reps_done    = 0;
	endtask

	task automatic predict_reading(input logic [RAW_W-1:0] raw);
		rep_result_t r;
		int s;
		acc_sum += int'(raw);
		acc_reads++;
		if (acc_reads < READS)
			return;
		s = acc_sum / READS;
		acc_sum = 0;
		acc_reads = 0;
		r.code = EV_NONE;
		r.width = '0;
		if (s >= int'(cur_cfg.th_high)) begin
			if (have_last && last_level >= int'(cur_cfg.th_low)) begin
				pulse_active = 1'b1;
				r.code = EV_DEAD;
				r.width = ticks_to_width(idle_ticks);
				idle_ticks = 0;
				if (run_ticks < TICK_MAX) run_ticks++;
			end
			last_level = s;
		end else if (s >= int'(cur_cfg.th_low)) begin
			if (pulse_active) begin
				if (run_ticks < TICK_MAX) run_ticks++;
			end else begin
				if (idle_ticks < TICK_MAX) idle_ticks++;
			end
			last_level = s;
		end else begin
			if (have_last && last_level > 0) begin
				pulse_active = 1'b0;
				r.width = ticks_to_width(run_ticks);
				run_ticks = 0;
				if (idle_ticks < TICK_MAX) idle_ticks++;
				if (r.width > cur_cfg.min_pulse) begin
					r.code = EV_REP;
					if (reps_done < REPS_MAX) reps_done++;
				end else begin
					r.code = EV_SHORT;
				end
			end
			last_level = 0;
		end
		have_last = 1'b1;
		r.reps = REPS_W'(reps_done);
		r.flag = pulse_active;
		r.avg  = RAW_W'(s);
		pending_results.push_back(r);
	endtask

	// callers sit just after a rising edge; valid stays up across back-to-back beats
	task automatic send_reading(input logic [RAW_W-1:0] raw);
		int gap;
		gap = gaps_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_reading <= raw;
		do @(posedge clk); while (!in_ready);
		predict_reading(raw);
		readings_sent++;
	endtask

	// a group of conversions whose floor average is exactly level
	task automatic send_sample(input int level);
		int left;
		int lo;
		int hi;
		int raw;
		left = level * READS + $urandom_range(0, READS - 1);
		if (left > RAW_MAX * READS) left = RAW_MAX * READS;
		for (int i = READS - 1; i >= 0; i--) begin
			lo = left - RAW_MAX * i;
			if (lo < 0) lo = 0;
			hi = (left < RAW_MAX) ? left : RAW_MAX;
			raw = $urandom_range(hi, lo);
			send_reading(RAW_W'(raw));
			left -= raw;
		end
	endtask

	function automatic int pick_level(input level_class_t cls);
		case (cls)
			LVL_LOW: begin
				if (cur_cfg.th_low == 0) return $urandom_range(0, RAW_MAX);
				return $urandom_range(0, int'(cur_cfg.th_low) - 1);
			end
			LVL_MID: begin
				if (cur_cfg.th_low >= cur_cfg.th_high) return $urandom_range(0, RAW_MAX);
				return $urandom_range(int'(cur_cfg.th_low), int'(cur_cfg.th_high) - 1);
			end
			default: return $urandom_range(int'(cur_cfg.th_high), RAW_MAX);
		endcase
	endfunction

	task automatic input_idle();
		in_valid <= 1'b0;
	endtask

	task automatic wait_results_done();
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic drain();
		input_idle();
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_THRESHOLD_HIGH: cur_cfg.th_high     = data[RAW_W-1:0];
			REG_THRESHOLD_LOW:  cur_cfg.th_low      = data[RAW_W-1:0];
			REG_TICK_PERIOD:    cur_cfg.tick_period = data[PERIOD_W-1:0];
			REG_MIN_PULSE:      cur_cfg.min_pulse   = data[WIDTH_W-1:0];
			default: ;
		endcase
	endtask

	// upper data bits carry junk; an unused index is written too and must be dropped
	task automatic load_settings(input cfg_t c);
		logic [CFG_DAT_W-1:0] d;
		d = CFG_DAT_W'($urandom);
		d[RAW_W-1:0] = c.th_high;
		write_reg(REG_THRESHOLD_HIGH, d);
		d = CFG_DAT_W'($urandom);
		d[RAW_W-1:0] = c.th_low;
		write_reg(REG_THRESHOLD_LOW, d);
		d = CFG_DAT_W'($urandom);
		d[PERIOD_W-1:0] = c.tick_period;
		write_reg(REG_TICK_PERIOD, d);
		write_reg(REG_MIN_PULSE, c.min_pulse);
		write_reg(CFG_IDX_W'($urandom_range(int'(REG_MIN_PULSE) + 1, IDX_MAX)),
			CFG_DAT_W'($urandom));
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	task automatic check_result();
		rep_result_t want;
		if (pending_results.size() == 0) begin
			$error("result beat with nothing expected: event_code %0d, averaged_sample %0d",
				event_code, averaged_sample);
			err_count++;
			return;
		end
		want = pending_results.pop_front();
		results_checked++;
		code_seen[int'(want.code)]++;
		check_field("event_code", 32'(want.code), 32'(event_code));
		check_field("width_ms", 32'(want.width), 32'(width_ms));
		check_field("rep_total", 32'(want.reps), 32'(rep_total));
		check_field("in_rep_flag", 32'(want.flag), 32'(in_rep_flag));
		check_field("averaged_sample", 32'(want.avg), 32'(averaged_sample));
	endtask

	// output side: random stall per beat, plus an optional long hold-off
	initial begin : result_sink
		int stall;
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = stall_on ? $urandom_range(0, 7) : 0;
			if (hold_left > 0) begin
				stall = hold_left;
				hold_left = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_result();
		end
	end

	task automatic test_reset_defaults();
		cfg_t c;
		send_sample(RAW_MAX);            // no previous sample: cannot start
		send_sample(0);                  // pulse end with no rep running, width 0
		send_sample(0);                  // run of lows: nothing
		send_sample(RAW_MAX);            // previous was low: no start
		send_sample(RAW_MAX);            // rep starts, dead width one tick
		send_sample(RAW_MAX);            // repeated high: dead width 0
		send_sample(TH_LOW_RST);         // exactly on low threshold, inside rep
		send_sample(0);                  // short pulse against default minimum
		drain();
		c = cur_cfg;
		c.min_pulse = WIDTH_W'(99);
		load_settings(c);
		send_sample(TH_HIGH_RST - 1);
		send_sample(TH_HIGH_RST);        // exactly on high threshold
		send_sample(TH_LOW_RST + 1);
		send_sample(TH_LOW_RST - 1);     // just below low: rep counted
	endtask

	task automatic test_random_settings();
		cfg_t c;
		int start;
		int pick;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain();
			c.th_low      = RAW_W'($urandom_range(0, 3000));
			c.th_high     = RAW_W'($urandom_range(int'(c.th_low), RAW_MAX));
			c.tick_period = ($urandom_range(0, 7) == 0) ? '0 : PERIOD_W'($urandom_range(1, 255));
			c.min_pulse   = WIDTH_W'($urandom_range(0, 8 * int'(c.tick_period)));
			case (phase)
				0: begin
					c.th_high = '1; c.th_low = '0; c.tick_period = '1; c.min_pulse = '0;
				end
				1: begin
					c.th_high = '0; c.th_low = '1; c.tick_period = '0; c.min_pulse = '1;
				end
				2: begin
					c.th_high = '0; c.th_low = '0; c.tick_period = PERIOD_W'(1); c.min_pulse = '0;
				end
				3: begin
					c.th_high = '1; c.th_low = '1; c.tick_period = PERIOD_W'(1); c.min_pulse = '1;
				end
				default: ;
			endcase
			load_settings(c);
			gaps_on  = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			start = readings_sent;
			while (readings_sent - start < ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					repeat (READS) send_reading(RAW_W'($urandom));
				end else if (pick < 3) begin
					send_sample(pick_level(level_class_t'($urandom_range(0, 2))));
				end else begin
					repeat ($urandom_range(0, 2)) send_sample(pick_level(LVL_MID));
					repeat ($urandom_range(2, 10)) send_sample(pick_level(LVL_HIGH));
					repeat ($urandom_range(0, 3)) send_sample(pick_level(LVL_MID));
					repeat ($urandom_range(1, 2)) send_sample(pick_level(LVL_LOW));
				end
			end
		end
		gaps_on  = 1'b1;
		stall_on = 1'b1;
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_left = LONG_HOLD;
		repeat (24) send_sample($urandom_range(0, RAW_MAX));
		// sender stops until the backlog is gone
		input_idle();
		wait_results_done();
		gaps_on = 1'b1;
		repeat (8) send_sample($urandom_range(0, RAW_MAX));
	endtask

	task automatic test_long_runs();
		cfg_t c;
		drain();
		c.th_high     = RAW_W'(3000);
		c.th_low      = RAW_W'(1000);
		c.tick_period = '1;
		c.min_pulse   = WIDTH_W'(longint'(LONG_RUN + 1) * 255 - 1);
		load_settings(c);
		gaps_on  = 1'b0;
		stall_on = 1'b0;
		send_sample(0);
		send_sample(0);
		repeat (LONG_RUN) send_sample(2000);  // long dead run
		send_sample(3500);
		repeat (LONG_RUN) send_sample(2000);  // long pulse run
		send_sample(0);                       // pulse one above minimum
		gaps_on  = 1'b1;
		stall_on = 1'b1;
	endtask

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		raw_reading <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_random_settings();
		test_backpressure();
		test_long_runs();
		drain();
		$display("Summary: %0d conversions sent, %0d results checked over %0d register settings",
			readings_sent, results_checked, settings_loaded);
		$display("Summary: events none %0d, dead %0d, short %0d, rep %0d",
			code_seen[0], code_seen[1], code_seen[2], code_seen[3]);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/emgrep_pkg.sv
rtl/emgrep_avg.sv
rtl/emgrep_det.sv
rtl/emg_rep_detector.sv
rtl/emgrep_checker.sv
sim/tb_emg_rep_detector.sv
